FILE: rtl/fpc_pkg.sv
// package: types, constants and codes for the frustum plane culler
`timescale 1ns / 1ps
`default_nettype none
package fpc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PLANE_W       = 48;
    localparam int COORD_W       = 32;
    localparam int RAW_W         = 33;
    localparam int NUM_PLANES    = 6;
    localparam int NUM_COEF      = 24;

    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_EXTRACT = 3'd1;
    localparam logic [2:0] MODE_POINT   = 3'd2;
    localparam logic [2:0] MODE_SPHERE  = 3'd3;
    localparam logic [2:0] MODE_BOX     = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic [30:0]        radius;
    } in_item_t;

    typedef struct packed {
        logic       inside_res;
        logic [1:0] test_kind;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       write_elem;
        logic       ext_start;
        logic       test_step;
        logic [2:0] plane_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ext_done;
        logic plane_out;
    } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/frustum_plane_culler_top.sv
// top level of the frustum plane culler
`timescale 1ns / 1ps
`default_nettype none
// Loads a 4x4 Q16.16 matrix element by element, extracts six normalized
// clip planes on an extract transfer and tests points, spheres and boxes.
// A test steps one plane per cycle through the dot product unit between
// accept and result; the result waits while an earlier one waits for m_ready.
// Extraction is shorter for a plane whose normal has zero length; its length is
// set by the bit-serial square root and the bit-serial divider, and no input is
// taken meanwhile.
module frustum_plane_culler_top #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fpc_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fpc_pkg::out_item_t      m_data
);

    fpc_pkg::dp_cmd_t cmd;
    fpc_pkg::dp_sts_t sts;

    fpc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_data.mode),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .res_inside (m_data.inside_res),
        .res_kind   (m_data.test_kind),
        .cmd        (cmd),
        .sts        (sts)
    );

    fpc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (s_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
`default_nettype wire

FILE: rtl/fpc_ctrl.sv
// controller: sequences loads, plane extraction and plane tests
`timescale 1ns / 1ps
`default_nettype none
module fpc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_mode,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     res_inside,
    output logic [1:0]               res_kind,
    output fpc_pkg::dp_cmd_t         cmd,
    input  wire fpc_pkg::dp_sts_t    sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXT  = 2'd1;
    localparam logic [1:0] ST_TEST = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] plane_reg, plane_next;
    logic       out_reg, out_next;
    logic       mval_reg, mval_next;
    logic       ins_reg, ins_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] tk_reg, tk_next;
    logic       acc;
    logic       m_free;

    assign m_free  = !mval_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign acc     = s_valid && s_ready;
    assign m_valid    = mval_reg;
    assign res_inside = ins_reg;
    assign res_kind   = kind_reg;

    always_comb begin
        state_next = state_reg;
        plane_next = plane_reg;
        out_next   = out_reg;
        mval_next  = mval_reg && !m_ready;
        ins_next   = ins_reg;
        kind_next  = kind_reg;
        tk_next    = tk_reg;
        cmd        = '0;
        cmd.plane_sel = plane_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.load_item = 1'b1;
                    if (s_mode == fpc_pkg::MODE_LOAD) begin
                        cmd.write_elem = 1'b1;
                    end else if (s_mode == fpc_pkg::MODE_EXTRACT) begin
                        cmd.ext_start = 1'b1;
                        state_next = ST_EXT;
                    end else if (s_mode == fpc_pkg::MODE_POINT ||
                                 s_mode == fpc_pkg::MODE_SPHERE ||
                                 s_mode == fpc_pkg::MODE_BOX) begin
                        plane_next = '0;
                        out_next   = 1'b0;
                        tk_next    = 2'(s_mode - fpc_pkg::MODE_POINT);
                        state_next = ST_TEST;
                    end
                end
            end
            ST_EXT: begin
                if (sts.ext_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TEST: begin
                cmd.test_step = 1'b1;
                out_next = out_reg || sts.plane_out;
                if (plane_reg == 3'(fpc_pkg::NUM_PLANES - 1)) begin
                    state_next = ST_WAIT;
                end else begin
                    plane_next = plane_reg + 3'd1;
                end
            end
            ST_WAIT: begin
                if (m_free) begin
                    mval_next  = 1'b1;
                    ins_next   = !out_reg;
                    kind_next  = tk_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
        plane_reg <= plane_next;
        out_reg   <= out_next;
        ins_reg   <= ins_next;
        kind_reg  <= kind_next;
        tk_reg    <= tk_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("accept while busy");
    a_result_after_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && m_free) |=> m_valid) else $error("result lost");
    a_plane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TEST |-> plane_reg < 3'(fpc_pkg::NUM_PLANES))
        else $error("plane index out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/fpc_dp.sv
// datapath: matrix and plane stores, extraction arithmetic and plane tests
`timescale 1ns / 1ps
`default_nettype none
module fpc_dp #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fpc_pkg::in_item_t item,
    input  wire fpc_pkg::dp_cmd_t  cmd,
    output fpc_pkg::dp_sts_t       sts
);

    localparam int PW   = fpc_pkg::PLANE_W;
    localparam int RW   = fpc_pkg::RAW_W;
    localparam int CW   = fpc_pkg::COORD_W;
    localparam int SQW  = 2 * RW + 2;
    localparam int RTW  = 34;
    localparam int QI   = 33 + 2 * FRAC_BITS;    // quotient step count, steps QI-1 down to 0
    localparam int QCW  = $clog2(QI + 2);
    localparam int MIW  = $clog2(RW);
    localparam int PRW  = 2 * PW + 2;            // test product width
    localparam int DW   = PRW + 3;
    // normal coefficients stay within +-1.0
    localparam int NW   = (2 * FRAC_BITS + 2 < PW) ? 2 * FRAC_BITS + 2 : PW;

    localparam logic [3:0] X_IDLE = 4'd0;
    localparam logic [3:0] X_RAW  = 4'd1;
    localparam logic [3:0] X_SQ   = 4'd2;
    localparam logic [3:0] X_ROOT = 4'd3;
    localparam logic [3:0] X_DIV  = 4'd4;
    localparam logic [3:0] X_WR   = 4'd5;

    // matrix memory, reset value undefined
    logic [31:0] mat_mem [16];
    // plane coefficients with per-entry valid bits
    logic signed [PW-1:0] pl_reg [fpc_pkg::NUM_COEF];
    logic [fpc_pkg::NUM_COEF-1:0] plv_reg;

    fpc_pkg::in_item_t itm_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            itm_reg <= item;
        end
        if (cmd.write_elem) begin
            mat_mem[item.elem_index] <= item.elem_value;
        end
    end

    // ---------------- extraction sequencer
    logic [3:0]  xs_reg, xs_next;
    logic [2:0]  xp_reg, xp_next;
    logic [2:0]  xk_reg, xk_next;
    logic [31:0] rd_reg;
    logic signed [RW-1:0] raw_reg [4];
    logic [SQW-1:0] ssum_reg;
    logic [RTW-1:0] root_reg;
    logic [5:0]  rb_reg;
    logic [QCW-1:0] qi_reg;
    logic [RW+1:0] rem_reg;
    logic [49:0] q_reg;
    logic [1:0]  mrow;
    logic [1:0]  kcoef;
    logic [3:0]  rd_addr;
    logic [31:0] rd_q;
    logic        rd_phase_reg;
    logic [RTW-1:0] cand;
    logic [2*RTW-1:0] cand_sq;
    logic [RW-1:0] mag_k;
    logic [2*RW-1:0] sq_k;
    logic [RW+1:0] rem_sh;
    logic        num_bit;
    logic signed [PW-1:0] sat_val;
    logic signed [RW+FRAC_BITS-1:0] shv;
    logic        xdone;

    assign mrow  = xp_reg[2:1];
    assign kcoef = xk_reg[1:0];
    // even read fetches row 3, odd read fetches selected row
    assign rd_addr = {kcoef, rd_phase_reg ? mrow : 2'd3};

    always_ff @(posedge aclk) begin
        rd_q <= mat_mem[rd_addr];
    end

    assign cand    = root_reg | (RTW'(1) << rb_reg);
    assign cand_sq = cand * cand;
    assign mag_k   = raw_reg[kcoef][RW-1] ? RW'(-raw_reg[kcoef]) : RW'(raw_reg[kcoef]);
    assign sq_k    = mag_k * mag_k;
    assign num_bit = (qi_reg >= QCW'(2 * FRAC_BITS)) ?
                     mag_k[MIW'(qi_reg - QCW'(2 * FRAC_BITS))] : 1'b0;
    assign rem_sh  = {rem_reg[RW:0], num_bit};
    assign shv     = (RW+FRAC_BITS)'(raw_reg[kcoef]) <<< FRAC_BITS;

    always_comb begin
        logic [49:0] qm;
        qm = q_reg;
        if (root_reg == '0) begin
            // unnormalized, saturate shifted raw value
            if (shv > (RW+FRAC_BITS)'(signed'({1'b0, {(PW-1){1'b1}}})))
                sat_val = {1'b0, {(PW-1){1'b1}}};
            else if (shv < -(RW+FRAC_BITS)'(signed'({1'b0, {(PW-1){1'b1}}})) - 1)
                sat_val = {1'b1, {(PW-1){1'b0}}};
            else
                sat_val = PW'(shv);
        end else if (raw_reg[kcoef][RW-1]) begin
            sat_val = (qm >= 50'(1) << (PW-1)) ? {1'b1, {(PW-1){1'b0}}} : PW'(-qm);
        end else begin
            sat_val = (qm > 50'({(PW-1){1'b1}})) ? {1'b0, {(PW-1){1'b1}}} : PW'(qm);
        end
    end

    always_comb begin
        xs_next = xs_reg;
        xp_next = xp_reg;
        xk_next = xk_reg;
        xdone   = 1'b0;
        unique case (xs_reg)
            X_IDLE: if (cmd.ext_start) begin
                xs_next = X_RAW; xp_next = '0; xk_next = '0;
            end
            X_RAW: if (rd_phase_reg) begin
                if (xk_reg == 3'd4) begin
                    xs_next = X_SQ; xk_next = '0;
                end else begin
                    xk_next = xk_reg + 3'd1;
                end
            end
            X_SQ: if (xk_reg == 3'd2) begin
                xs_next = X_ROOT;
            end else begin
                xk_next = xk_reg + 3'd1;
            end
            X_ROOT: if (rb_reg == '0) begin
                xs_next = X_DIV; xk_next = '0;
            end
            X_DIV: if (root_reg == '0 || qi_reg == '0) begin
                xs_next = X_WR;
            end
            X_WR: begin
                if (xk_reg == 3'd3) begin
                    xk_next = '0;
                    if (xp_reg == 3'(fpc_pkg::NUM_PLANES - 1)) begin
                        xs_next = X_IDLE; xdone = 1'b1;
                    end else begin
                        xp_next = xp_reg + 3'd1; xs_next = X_RAW;
                    end
                end else begin
                    xk_next = xk_reg + 3'd1; xs_next = X_DIV;
                end
            end
            default: xs_next = X_IDLE;
        endcase
    end

    assign sts.ext_done = xdone;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xs_reg  <= X_IDLE;
            plv_reg <= '0;
        end else begin
            xs_reg <= xs_next;
            if (xs_reg == X_WR) begin
                plv_reg[{xp_reg, kcoef}] <= 1'b1;
            end
        end
        xp_reg <= xp_next;
        xk_reg <= xk_next;
        if (xs_reg == X_WR) begin
            pl_reg[{xp_reg, kcoef}] <= sat_val;
        end
        unique case (xs_reg)
            X_IDLE: begin
                rd_phase_reg <= 1'b0;
            end
            X_RAW: begin
                // pipelined reads: data from previous address arrives now
                if (!rd_phase_reg) begin
                    rd_phase_reg <= 1'b1;
                    if (xk_reg != 3'd0) begin
                        raw_reg[2'(xk_reg - 3'd1)] <= xp_reg[0] ?
                            RW'(signed'(rd_reg)) - RW'(signed'(rd_q)) :
                            RW'(signed'(rd_reg)) + RW'(signed'(rd_q));
                    end
                end else begin
                    rd_phase_reg <= 1'b0;
                    rd_reg <= rd_q;
                end
                ssum_reg <= '0;
            end
            X_SQ: begin
                ssum_reg <= ssum_reg + SQW'(sq_k);
                root_reg <= '0;
                rb_reg   <= 6'(RTW - 1);
            end
            X_ROOT: begin
                if (cand_sq <= ssum_reg)
                    root_reg <= cand;
                if (rb_reg != '0) rb_reg <= rb_reg - 6'd1;
                rem_reg <= '0; q_reg <= '0; qi_reg <= QCW'(QI - 1);
            end
            X_DIV: begin
                if (rem_sh >= (RW+2)'(root_reg)) begin
                    rem_reg <= rem_sh - (RW+2)'(root_reg);
                    q_reg   <= ((q_reg << 1) | 50'd1) > (50'd1 << 48) ?
                               (50'd1 << 48) : ((q_reg << 1) | 50'd1);
                end else begin
                    rem_reg <= rem_sh;
                    q_reg   <= (q_reg << 1) > (50'd1 << 48) ?
                               (50'd1 << 48) : (q_reg << 1);
                end
                if (qi_reg != '0) qi_reg <= qi_reg - QCW'(1);
            end
            X_WR: begin
                rem_reg <= '0; q_reg <= '0; qi_reg <= QCW'(QI - 1);
            end
            default: ;
        endcase
    end

    // ---------------- plane test, one plane per cycle
    logic signed [PW-1:0] ca, cb, cc, cd;
    logic signed [NW-1:0] na, nb, nc;
    logic signed [CW-1:0] vx, vy, vz;
    logic signed [NW+CW-1:0] px, py, pz;
    logic signed [DW-1:0] dot_sum;
    logic signed [DW-1:0] rterm;
    logic [4:0] base;

    assign base = {cmd.plane_sel, 2'b00};
    assign ca = plv_reg[base]        ? pl_reg[base]        : '0;
    assign cb = plv_reg[base + 5'd1] ? pl_reg[base + 5'd1] : '0;
    assign cc = plv_reg[base + 5'd2] ? pl_reg[base + 5'd2] : '0;
    assign cd = plv_reg[base + 5'd3] ? pl_reg[base + 5'd3] : '0;
    assign na = NW'(ca);
    assign nb = NW'(cb);
    assign nc = NW'(cc);

    always_comb begin
        logic box;
        box = (itm_reg.mode == fpc_pkg::MODE_BOX);
        vx = (box && !ca[PW-1]) ? itm_reg.second_x : itm_reg.first_x;
        vy = (box && !cb[PW-1]) ? itm_reg.second_y : itm_reg.first_y;
        vz = (box && !cc[PW-1]) ? itm_reg.second_z : itm_reg.first_z;
        rterm = (itm_reg.mode == fpc_pkg::MODE_SPHERE) ?
                (DW'($signed({1'b0, itm_reg.radius})) <<< (2 * FRAC_BITS)) : '0;
        px = na * vx;
        py = nb * vy;
        pz = nc * vz;
        dot_sum = DW'(px) + DW'(py) + DW'(pz)
                + (DW'(cd) <<< FRAC_BITS) + rterm;
    end

    assign sts.plane_out = cmd.test_step && dot_sum[DW-1];

`ifndef SYNTHESIS
    a_ext_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.test_step |-> xs_reg == X_IDLE) else $error("test during extraction");
    a_ext_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ext_start |-> xs_reg == X_IDLE) else $error("extraction restarted");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.ext_done |=> xs_reg == X_IDLE) else $error("done without idle");
`endif

endmodule
`default_nettype wire
